>>> rtl/pasv_pkg.sv
// Shared types and byte codes for the passive-mode reply number parser.
package pasv_pkg;

   typedef enum logic [2:0] {
      LINE_SEEK   = 3'b001,
      LINE_LIST   = 3'b010,
      LINE_CLOSED = 3'b100
   } line_phase_type;

   typedef enum logic [3:0] {
      TOK_BETWEEN = 4'b0001,
      TOK_BLANK   = 4'b0010,
      TOK_DIGITS  = 4'b0100,
      TOK_REST    = 4'b1000
   } token_phase_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int         NUM_DEPTH = 6;
   localparam logic [2:0] NUM_COUNT = 3'd6;

endpackage

>>> rtl/pasv_reply_number_parser.sv
// Top level of the passive-mode reply number parser.
//
// The block takes one byte of a reply line per cycle and returns one result
// on the byte marked last: reply_ok when a '(' and six numbers were seen, the
// four address octets, the port as fifth*256+sixth and a range flag. Bytes
// are accepted back to back at one per cycle; a result comes from its last
// byte by way of the input register, where the byte sits while the state
// update that feeds the result register is worked out, and then the result
// register, which loads from that update. The per-byte cost is the decimal
// accumulate (times ten plus digit, then saturate) and the sign fix of a
// closing token, all within the one state update. The input register keeps
// taking bytes while a result waits; only a second last byte stalls until
// the pending result is taken.
module pasv_reply_number_parser #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_ok,
   output logic [7:0]  rsp_addr_octet_0,
   output logic [7:0]  rsp_addr_octet_1,
   output logic [7:0]  rsp_addr_octet_2,
   output logic [7:0]  rsp_addr_octet_3,
   output logic [15:0] rsp_port_number,
   output logic        rsp_range_error
);
   import pasv_pkg::*;

   localparam int VW = VALUE_WIDTH;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] ch_ff;
   logic       last_ff;
   logic       advance;

   // Parser state.
   line_phase_type  lp_ff, lp_in;
   token_phase_type tp_ff, tp_in;
   logic [2:0]      nf_ff, nf_in;
   logic [VW-1:0]   rv_ff, rv_in;
   logic            ms_ff, ms_in;
   logic            rf_ff, rf_in;
   logic [VW-1:0]   store_ff [NUM_DEPTH];
   logic [VW-1:0]   store_in [NUM_DEPTH];

   // Result register.
   logic        rsp_valid_ff;
   logic        ok_ff, ok_in;
   logic [7:0]  oct0_ff, oct1_ff, oct2_ff, oct3_ff;
   logic [7:0]  oct0_in, oct1_in, oct2_in, oct3_in;
   logic [15:0] port_ff, port_in;
   logic        rerr_ff, rerr_in;

   // Byte classes and the decimal accumulate.
   logic          is_digit;
   logic          is_blank;
   logic [VW+3:0] digit_sum;
   logic          digit_sat;
   logic [VW-1:0] digit_val;

   assign is_digit  = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
   assign is_blank  = (ch_ff == CH_SPACE) || ((ch_ff >= CH_TAB) && (ch_ff <= CH_CR));
   assign digit_sum = {1'b0, rv_ff, 3'b000} + {3'b000, rv_ff, 1'b0}
                    + {{VW{1'b0}}, ch_ff[3:0]};
   assign digit_sat = |digit_sum[VW+3:VW];
   assign digit_val = digit_sat ? {VW{1'b1}} : digit_sum[VW-1:0];

   assign advance   = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || advance);

   always_comb begin
      token_phase_type tp0;
      token_phase_type tb_tp;
      logic [VW-1:0]   tb_rv;
      logic            tb_ms;
      logic            tb_sat;
      token_phase_type tok_tp;
      logic [VW-1:0]   tok_rv;
      logic            tok_ms;
      logic            token_path;
      logic            end_list;
      logic            comma;
      logic            do_close;
      logic            do_store;
      logic            negative;
      logic [VW-1:0]   neg_val;
      logic [VW-1:0]   store_val;
      logic [VW+15:0]  sixth_ext;

      tp0    = (tp_ff == TOK_BETWEEN) ? TOK_BLANK : tp_ff;
      tb_tp  = tp0;
      tb_rv  = rv_ff;
      tb_ms  = ms_ff;
      tb_sat = 1'b0;
      unique case (tp0)
         TOK_BLANK: begin
            if (is_blank) begin
               tb_tp = TOK_BLANK;
            end else if (ch_ff == CH_PLUS) begin
               tb_tp = TOK_DIGITS;
            end else if (ch_ff == CH_MINUS) begin
               tb_ms = 1'b1;
               tb_tp = TOK_DIGITS;
            end else if (is_digit) begin
               tb_rv  = digit_val;
               tb_sat = digit_sat;
               tb_tp  = TOK_DIGITS;
            end else begin
               tb_tp = TOK_REST;
            end
         end
         TOK_DIGITS: begin
            if (is_digit) begin
               tb_rv  = digit_val;
               tb_sat = digit_sat;
            end else begin
               tb_tp = TOK_REST;
            end
         end
         TOK_REST: begin
            tb_tp = TOK_REST;
         end
         default: begin
            tb_tp = tp0;
         end
      endcase

      lp_in      = lp_ff;
      token_path = 1'b0;
      end_list   = 1'b0;
      comma      = 1'b0;
      unique case (lp_ff)
         LINE_SEEK: begin
            if (ch_ff == CH_LPAREN) begin
               lp_in = LINE_LIST;
            end
         end
         LINE_LIST: begin
            if ((ch_ff == CH_RPAREN) || (ch_ff == CH_NUL)) begin
               end_list = 1'b1;
               lp_in    = LINE_CLOSED;
            end else if (ch_ff == CH_COMMA) begin
               comma = 1'b1;
            end else begin
               token_path = 1'b1;
            end
         end
         LINE_CLOSED: begin
            lp_in = LINE_CLOSED;
         end
         default: begin
            lp_in = lp_ff;
         end
      endcase

      tok_tp = token_path ? tb_tp : tp_ff;
      tok_rv = token_path ? tb_rv : rv_ff;
      tok_ms = token_path ? tb_ms : ms_ff;

      // A token closes on a separator, on the list end, or when the line ends
      // while the list is still open.
      do_close  = (lp_ff == LINE_LIST) && (end_list || comma || last_ff);
      do_store  = do_close && (tok_tp != TOK_BETWEEN) && (nf_ff < NUM_COUNT);
      negative  = tok_ms && (|tok_rv);
      neg_val   = ~tok_rv + {{(VW-1){1'b0}}, 1'b1};
      store_val = negative ? neg_val : tok_rv;

      rf_in = rf_ff || (token_path && tb_sat)
           || (do_store && ((|tok_rv[VW-1:8]) || negative));
      nf_in = do_store ? (nf_ff + 3'd1) : nf_ff;
      tp_in = do_close ? TOK_BETWEEN : tok_tp;
      rv_in = do_close ? {VW{1'b0}} : tok_rv;
      ms_in = do_close ? 1'b0 : tok_ms;

      for (int i = 0; i < NUM_DEPTH; i++) begin
         store_in[i] = (do_store && (nf_ff == 3'(i))) ? store_val : store_ff[i];
      end

      ok_in     = (lp_in != LINE_SEEK) && (nf_in == NUM_COUNT);
      sixth_ext = {16'h0000, store_in[5]};
      oct0_in   = ok_in ? store_in[0][7:0] : 8'h00;
      oct1_in   = ok_in ? store_in[1][7:0] : 8'h00;
      oct2_in   = ok_in ? store_in[2][7:0] : 8'h00;
      oct3_in   = ok_in ? store_in[3][7:0] : 8'h00;
      port_in   = ok_in ? ({store_in[4][7:0], 8'h00} + sixth_ext[15:0]) : 16'h0000;
      rerr_in   = ok_in && rf_in;

      // The line is done: the line, token, count, value, sign and range state start over.
      if (last_ff) begin
         lp_in = LINE_SEEK;
         tp_in = TOK_BETWEEN;
         nf_in = 3'd0;
         rv_in = {VW{1'b0}};
         ms_in = 1'b0;
         rf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lp_ff        <= LINE_SEEK;
         tp_ff        <= TOK_BETWEEN;
         nf_ff        <= 3'd0;
         rv_ff        <= {VW{1'b0}};
         ms_ff        <= 1'b0;
         rf_ff        <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            lp_ff <= lp_in;
            tp_ff <= tp_in;
            nf_ff <= nf_in;
            rv_ff <= rv_in;
            ms_ff <= ms_in;
            rf_ff <= rf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff   <= req_ch;
         last_ff <= req_last;
      end
      if (advance) begin
         for (int i = 0; i < NUM_DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
      if (advance && last_ff) begin
         ok_ff   <= ok_in;
         oct0_ff <= oct0_in;
         oct1_ff <= oct1_in;
         oct2_ff <= oct2_in;
         oct3_ff <= oct3_in;
         port_ff <= port_in;
         rerr_ff <= rerr_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_ok     = ok_ff;
   assign rsp_addr_octet_0 = oct0_ff;
   assign rsp_addr_octet_1 = oct1_ff;
   assign rsp_addr_octet_2 = oct2_ff;
   assign rsp_addr_octet_3 = oct3_ff;
   assign rsp_port_number  = port_ff;
   assign rsp_range_error  = rerr_ff;

endmodule

>>> rtl/pasv_checker.sv
// Port-level assertions for the passive-mode reply number parser, with its bind.
module pasv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_reply_ok,
   input logic [7:0]  rsp_addr_octet_0,
   input logic [7:0]  rsp_addr_octet_1,
   input logic [7:0]  rsp_addr_octet_2,
   input logic [7:0]  rsp_addr_octet_3,
   input logic [15:0] rsp_port_number,
   input logic        rsp_range_error
);

   // A stalled result transaction keeps its ok flag, port and range flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_ok)
         && $stable(rsp_port_number) && $stable(rsp_range_error))
      else $error("result changed while stalled");

   // A failed parse reports nothing but zeros.
   a_not_ok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reply_ok |-> rsp_addr_octet_0 == 8'h00
         && rsp_addr_octet_1 == 8'h00 && rsp_addr_octet_2 == 8'h00
         && rsp_addr_octet_3 == 8'h00 && rsp_port_number == 16'h0000
         && !rsp_range_error)
      else $error("fields not zero on a failed parse");

   // A fresh result must be preceded by an accepted last byte.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a last byte");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pasv_reply_number_parser pasv_checker u_pasv_checker (.*);

>>> test/tb_pasv_reply_number_parser.sv
// Self-checking testbench for the passive-mode reply number parser, with directed and random lines.
module tb_pasv_reply_number_parser;
   import pasv_pkg::*;

   localparam int          VALUE_WIDTH      = 16;
   localparam int unsigned VALUE_MAX        = 2 ** VALUE_WIDTH - 1;
   localparam int          RANDOM_BYTES     = 200;
   localparam int          RANDOM_LINES_MIN = 6;
   localparam int          DRAIN_CYCLES     = 20;
   localparam int          LIMIT_CYCLES     = 400000;

   typedef logic [7:0] line_type [$];

   typedef struct packed {
      logic        ok;
      logic [7:0]  octet_0;
      logic [7:0]  octet_1;
      logic [7:0]  octet_2;
      logic [7:0]  octet_3;
      logic [15:0] port;
      logic        range_err;
   } reply_fields_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_ch;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_reply_ok;
   logic [7:0]  rsp_addr_octet_0;
   logic [7:0]  rsp_addr_octet_1;
   logic [7:0]  rsp_addr_octet_2;
   logic [7:0]  rsp_addr_octet_3;
   logic [15:0] rsp_port_number;
   logic        rsp_range_error;

   pasv_reply_number_parser #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_ok     (rsp_reply_ok),
      .rsp_addr_octet_0 (rsp_addr_octet_0),
      .rsp_addr_octet_1 (rsp_addr_octet_1),
      .rsp_addr_octet_2 (rsp_addr_octet_2),
      .rsp_addr_octet_3 (rsp_addr_octet_3),
      .rsp_port_number  (rsp_port_number),
      .rsp_range_error  (rsp_range_error)
   );

   // Parser state as predicted by the testbench.
   line_phase_type         line_st;
   token_phase_type        tok_st;
   int                     found;
   int unsigned            mag;
   bit                     neg;
   bit                     rng;
   logic [VALUE_WIDTH-1:0] nums [NUM_DEPTH];

   reply_fields_type expected_replies [$];

   bit idle_on = 1'b1;
   int errors;
   int bytes_sent;
   int lines_sent;
   int replies_checked;
   int replies_ok;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timeout after %0d cycles, %0d replies still pending",
               LIMIT_CYCLES, expected_replies.size());
      $display("[pasv_reply_number_parser] ERROR");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void clear_line();
      line_st = LINE_SEEK;
      tok_st  = TOK_BETWEEN;
      found   = 0;
      mag     = 0;
      neg     = 1'b0;
      rng     = 1'b0;
   endfunction

   function automatic void end_token();
      int unsigned v;
      if (tok_st != TOK_BETWEEN && found < NUM_DEPTH) begin
         v = mag;
         if (v > 255)
            rng = 1'b1;
         // A minus sign on a nonzero magnitude stores the two's complement.
         if (neg && v != 0) begin
            rng = 1'b1;
            v   = (~v + 1) & VALUE_MAX;
         end
         nums[found] = v[VALUE_WIDTH-1:0];
         found++;
      end
      tok_st = TOK_BETWEEN;
      mag    = 0;
      neg    = 1'b0;
   endfunction

   function automatic void take_digit(logic [7:0] c);
      longint unsigned v;
      v = longint'(mag) * 10 + (c - CH_ZERO);
      if (v > VALUE_MAX) begin
         v   = VALUE_MAX;
         rng = 1'b1;
      end
      mag = 32'(v);
   endfunction

   function automatic void predict_byte(logic [7:0] c, logic l);
      reply_fields_type r;
      bit               digit;
      bit               blank;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      blank = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
      case (line_st)
         LINE_SEEK: begin
            if (c == CH_LPAREN)
               line_st = LINE_LIST;
         end
         LINE_LIST: begin
            if (c == CH_RPAREN || c == CH_NUL) begin
               end_token();
               line_st = LINE_CLOSED;
            end else if (c == CH_COMMA) begin
               end_token();
            end else begin
               if (tok_st == TOK_BETWEEN)
                  tok_st = TOK_BLANK;
               if (tok_st == TOK_BLANK) begin
                  if (blank) begin
                     tok_st = TOK_BLANK;
                  end else if (c == CH_PLUS) begin
                     tok_st = TOK_DIGITS;
                  end else if (c == CH_MINUS) begin
                     neg    = 1'b1;
                     tok_st = TOK_DIGITS;
                  end else if (digit) begin
                     take_digit(c);
                     tok_st = TOK_DIGITS;
                  end else begin
                     tok_st = TOK_REST;
                  end
               end else if (tok_st == TOK_DIGITS) begin
                  if (digit)
                     take_digit(c);
                  else
                     tok_st = TOK_REST;
               end
            end
         end
         default: begin
         end
      endcase
      if (l) begin
         if (line_st == LINE_LIST)
            end_token();
         r = '0;
         if (line_st != LINE_SEEK && found == NUM_DEPTH) begin
            r.ok        = 1'b1;
            r.octet_0   = nums[0][7:0];
            r.octet_1   = nums[1][7:0];
            r.octet_2   = nums[2][7:0];
            r.octet_3   = nums[3][7:0];
            r.port      = 16'((nums[4] << 8) + nums[5]);
            r.range_err = rng;
         end
         expected_replies.push_back(r);
         lines_sent++;
         clear_line();
      end
   endfunction

   function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   // Reply checker: every accepted result transaction is compared with the oldest prediction.
   always @(posedge clock) begin
      reply_fields_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual ok=%0d port=%0d",
                     $time, rsp_reply_ok, rsp_port_number);
            errors++;
         end else begin
            e = expected_replies.pop_front();
            check_field("reply_ok", 32'(e.ok), 32'(rsp_reply_ok));
            check_field("addr_octet_0", 32'(e.octet_0), 32'(rsp_addr_octet_0));
            check_field("addr_octet_1", 32'(e.octet_1), 32'(rsp_addr_octet_1));
            check_field("addr_octet_2", 32'(e.octet_2), 32'(rsp_addr_octet_2));
            check_field("addr_octet_3", 32'(e.octet_3), 32'(rsp_addr_octet_3));
            check_field("port_number", 32'(e.port), 32'(rsp_port_number));
            check_field("range_error", 32'(e.range_err), 32'(rsp_range_error));
            replies_checked++;
            if (e.ok)
               replies_ok++;
         end
      end
   end

   // Result-side back-pressure: random stalls, always ready while idling is off.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!idle_on) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = idle_cycles();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   function automatic line_type text(string s);
      line_type q;
      int       i;
      for (i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   // Valid stays high from one transaction to the next unless a gap is drawn.
   task automatic send_byte(logic [7:0] c, logic l);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= l;
      do
         @(posedge clock);
      while (!req_ready);
      predict_byte(c, l);
      bytes_sent++;
   endtask

   task automatic send_line(line_type ln);
      int i;
      for (i = 0; i < ln.size(); i++)
         send_byte(ln[i], i == ln.size() - 1);
   endtask

   task automatic test_basic_replies();
      send_line(text("227 (10,0,0,1,19,137)"));
      send_line(text("(255,255,255,255,255,255)"));
      send_line(text("(0,0,0,0,0,0)"));
   endtask

   task automatic test_number_extremes();
      // Saturation, negative values, minus zero, plus sign and leading zeros.
      send_line(text("(65535,99999,-1,-0,+7,256)"));
      send_line(text("(-65535,-300,007,1,0,1)"));
      send_line(text("(+,-,a,-b, -9z,1)"));
   endtask

   task automatic test_special_cases();
      line_type ln;
      send_line(text("(  1,\t2 ,, 3x,4 ,5,6,7,8)"));
      send_line(text("(\v1,\f2,\r3,\n4, 5,6)"));
      send_line(text("(1, ,3,4,5,6)"));
      send_line(text("()"));
      ln = text("(1,2,3,4,5,6");
      ln.push_back(CH_NUL);
      ln = {ln, text("(7,8")};
      send_line(ln);
      send_line(text("no list here"));
      send_line(text("(1,2,3,4,5"));
      send_line(text("(1,2,3,4,5,6"));
      send_line(text("(1,2,3,4,5,6)(9)"));
      send_line(text("("));
      send_line(text("x"));
   endtask

   task automatic test_random_lines();
      line_type    ln;
      int          kind;
      int          ntok;
      int          t;
      int          i;
      int          r;
      int          keep;
      int          start;
      int          nlines;
      int unsigned val;
      string       digits;
      logic [7:0]  c;
      start  = bytes_sent;
      nlines = 0;
      while (bytes_sent - start < RANDOM_BYTES || nlines < RANDOM_LINES_MIN) begin
         if (nlines % 8 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         ln.delete();
         kind = $urandom_range(0, 9);
         if (kind == 7) begin
            repeat ($urandom_range(1, 12)) ln.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(0, 4)) begin
               c = 8'($urandom_range(1, 255));
               if (c == CH_LPAREN)
                  c = CH_SPACE;
               ln.push_back(c);
            end
            ln.push_back(CH_LPAREN);
            if (kind == 9)
               ntok = $urandom_range(7, 9);
            else if (kind == 8)
               ntok = $urandom_range(0, 6);
            else
               ntok = 6;
            for (t = 0; t < ntok; t++) begin
               if (t > 0) begin
                  ln.push_back(CH_COMMA);
                  if ($urandom_range(0, 11) == 0)
                     ln.push_back(CH_COMMA);
               end
               if ($urandom_range(0, 4) == 0) begin
                  repeat ($urandom_range(1, 2)) begin
                     r = $urandom_range(0, 5);
                     ln.push_back(r == 5 ? CH_SPACE : 8'(CH_TAB + r));
                  end
               end
               r = $urandom_range(0, 19);
               if (r == 0)
                  ln.push_back(CH_MINUS);
               else if (r == 1)
                  ln.push_back(CH_PLUS);
               r = $urandom_range(0, 19);
               if (r < 14)
                  val = $urandom_range(0, 255);
               else if (r < 16)
                  val = $urandom_range(256, 999);
               else
                  val = $urandom_range(1000, 9999999);
               // The last two draws leave the token without digits.
               if (r < 18) begin
                  if ($urandom_range(0, 15) == 0)
                     ln.push_back(CH_ZERO);
                  digits = $sformatf("%0d", val);
                  for (i = 0; i < digits.len(); i++)
                     ln.push_back(digits[i]);
               end
               if ($urandom_range(0, 9) == 0) begin
                  c = 8'($urandom_range(1, 255));
                  if (c == CH_COMMA || c == CH_RPAREN)
                     c = "x";
                  ln.push_back(c);
               end
            end
            r = $urandom_range(0, 19);
            if (r < 16)
               ln.push_back(CH_RPAREN);
            else if (r < 18)
               ln.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) ln.push_back(8'($urandom_range(0, 255)));
            if (kind == 8) begin
               keep = $urandom_range(1, ln.size());
               while (ln.size() > keep)
                  void'(ln.pop_back());
            end
         end
         send_line(ln);
         nlines++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      errors          = 0;
      bytes_sent      = 0;
      lines_sent      = 0;
      replies_checked = 0;
      replies_ok      = 0;
      clear_line();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_ch    <= CH_NUL;
      req_last  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_replies();
      test_number_extremes();
      test_special_cases();
      test_random_lines();

      req_valid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d replies never arrived", $time, expected_replies.size());
         errors++;
      end

      $display("Sent %0d bytes in %0d lines; %0d replies checked, %0d of them ok.",
               bytes_sent, lines_sent, replies_checked, replies_ok);
      $display("Lines covered saturation, signs, blank and empty tokens, early ends; %0d errors.",
               errors);
      if (errors == 0)
         $display("[pasv_reply_number_parser] OK");
      else
         $display("[pasv_reply_number_parser] ERROR");
      $finish;
   end

endmodule
